// ----- rtl/vfcao_pkg.sv -----
// shared types, constants and occlusion tables for the voxel face cull block
package vfcao_pkg;

  // fixed field widths
  localparam int MAT_W  = 7;
  localparam int POSX_W = 5;
  localparam int POSY_W = 8;
  localparam int POSZ_W = 5;
  localparam int FACE_W = 3;
  localparam int OCCL_W = 2;

  // 3x3x3 neighborhood, index = (dx+1) + 3*(dy+1) + 9*(dz+1)
  localparam int CUBE_N = 27;
  typedef logic [4:0]        cube_idx_t;
  typedef logic [CUBE_N-1:0] cube_t;
  localparam cube_idx_t CUBE_CENTER = 5'd13;
  localparam cube_idx_t CUBE_LAST   = 5'd26;

  typedef enum logic [0:0] {
    REQ_WRITE = 1'b0,
    REQ_MESH  = 1'b1
  } req_type_t;

  localparam int NUM_FACES = 6;
  typedef logic [FACE_W-1:0] face_t;
  localparam face_t FACE_LAST = 3'd5;

  // direct neighbor of each face: back, front, left, right, bottom, top
  localparam cube_idx_t FACE_NBR [NUM_FACES] = '{
    5'd22, 5'd4, 5'd14, 5'd12, 5'd10, 5'd16
  };

  // per face, per vertex: side 1, side 2, corner
  localparam cube_idx_t AO_IDX [NUM_FACES][4][3] = '{
    '{'{5'd23, 5'd25, 5'd26}, '{5'd25, 5'd21, 5'd24},
      '{5'd21, 5'd19, 5'd18}, '{5'd19, 5'd23, 5'd20}},
    '{'{5'd3,  5'd7,  5'd6 }, '{5'd7,  5'd5,  5'd8 },
      '{5'd5,  5'd1,  5'd2 }, '{5'd1,  5'd3,  5'd0 }},
    '{'{5'd5,  5'd17, 5'd8 }, '{5'd17, 5'd23, 5'd26},
      '{5'd23, 5'd11, 5'd20}, '{5'd11, 5'd5,  5'd2 }},
    '{'{5'd21, 5'd15, 5'd24}, '{5'd15, 5'd3,  5'd6 },
      '{5'd3,  5'd9,  5'd0 }, '{5'd9,  5'd21, 5'd18}},
    '{'{5'd9,  5'd1,  5'd0 }, '{5'd1,  5'd11, 5'd2 },
      '{5'd11, 5'd19, 5'd20}, '{5'd19, 5'd9,  5'd18}},
    '{'{5'd15, 5'd25, 5'd24}, '{5'd25, 5'd17, 5'd26},
      '{5'd17, 5'd7,  5'd8 }, '{5'd7,  5'd15, 5'd6 }}
  };

  // one face result as it leaves the block
  typedef struct packed {
    face_t              face_id;
    logic [OCCL_W-1:0]  occl_v0;
    logic [OCCL_W-1:0]  occl_v1;
    logic [OCCL_W-1:0]  occl_v2;
    logic [OCCL_W-1:0]  occl_v3;
    logic [MAT_W-1:0]   material;
    logic               last;
  } face_res_t;

  // vertex occlusion: 0 when both sides solid, else 3 minus solid count
  function automatic logic [OCCL_W-1:0] ao_level(cube_t cube, face_t f, logic [1:0] v);
    logic              s0;
    logic              s1;
    logic              s2;
    logic [1:0]        sum;
    logic [OCCL_W-1:0] lvl;
    lvl = '0;
    if (f <= FACE_LAST) begin
      s0  = cube[AO_IDX[f][v][0]];
      s1  = cube[AO_IDX[f][v][1]];
      s2  = cube[AO_IDX[f][v][2]];
      sum = {1'b0, s0} + {1'b0, s1} + {1'b0, s2};
      if (s0 && s1) begin
        lvl = '0;
      end else begin
        lvl = 2'd3 - sum;
      end
    end
    return lvl;
  endfunction

endpackage

// ----- rtl/vfcao_store.sv -----
// voxel material memory with one write port, one registered read port and a clearing sweep
module vfcao_store #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [vfcao_pkg::MAT_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [vfcao_pkg::MAT_W-1:0] rd_data,
  output logic                     clearing
);
  import vfcao_pkg::*;

  logic [MAT_W-1:0] mem [DEPTH];
  logic [AW-1:0]    clr_addr;

  // sweep every entry to air after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // write port, the sweep has priority
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/vfcao_gather.sv -----
// walks the 3x3x3 neighborhood of a voxel through the store, one read per cycle
module vfcao_gather #(
  parameter int CHUNK_X = 32,
  parameter int CHUNK_Y = 256,
  parameter int CHUNK_Z = 32,
  parameter int CW      = 10,
  parameter int AW      = 18
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [CW-1:0]        cx,
  input  logic signed [CW-1:0]        cy,
  input  logic signed [CW-1:0]        cz,
  input  logic                        border_solid,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [vfcao_pkg::MAT_W-1:0] rd_data,
  output vfcao_pkg::cube_t            cube,
  output logic [vfcao_pkg::MAT_W-1:0] material,
  output logic                        done
);
  import vfcao_pkg::*;

  logic                 issuing;
  logic [1:0]           ox;
  logic [1:0]           oy;
  logic [1:0]           oz;
  cube_idx_t            cnt;
  logic signed [CW-1:0] nx;
  logic signed [CW-1:0] ny;
  logic signed [CW-1:0] nz;
  logic                 in_chunk;
  logic                 vld_d;
  logic                 oob_d;
  cube_idx_t            idx_d;

  // neighbor coordinate for the current offset
  assign nx = cx + $signed(CW'(ox)) - $signed(CW'(1));
  assign ny = cy + $signed(CW'(oy)) - $signed(CW'(1));
  assign nz = cz + $signed(CW'(oz)) - $signed(CW'(1));

  assign in_chunk = !nx[CW-1] && (int'(nx) < CHUNK_X) &&
                    !ny[CW-1] && (int'(ny) < CHUNK_Y) &&
                    !nz[CW-1] && (int'(nz) < CHUNK_Z);

  // linear store address, only used when inside
  assign rd_addr = AW'($unsigned(nx)) +
                   AW'($unsigned(ny)) * AW'(CHUNK_X) +
                   AW'($unsigned(nz)) * AW'(CHUNK_X * CHUNK_Y);
  assign rd_en   = issuing && in_chunk;

  // offset counters, x fastest
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      vld_d   <= 1'b0;
    end else begin
      vld_d <= issuing;
      if (start) begin
        issuing <= 1'b1;
      end else if (issuing && cnt == CUBE_LAST) begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ox  <= '0;
      oy  <= '0;
      oz  <= '0;
      cnt <= '0;
    end else if (issuing) begin
      cnt <= cnt + 5'd1;
      if (ox == 2'd2) begin
        ox <= '0;
        if (oy == 2'd2) begin
          oy <= '0;
          oz <= oz + 2'd1;
        end else begin
          oy <= oy + 2'd1;
        end
      end else begin
        ox <= ox + 2'd1;
      end
    end
    oob_d <= !in_chunk;
    idx_d <= cnt;
  end

  // collect solid bits as read data returns
  always_ff @(posedge clk) begin
    if (vld_d) begin
      cube[idx_d] <= oob_d ? border_solid : (rd_data != '0);
      if (idx_d == CUBE_CENTER) begin
        material <= rd_data;
      end
    end
  end

  assign done = vld_d && (idx_d == CUBE_LAST);

endmodule

// ----- rtl/vfcao_emit.sv -----
// picks visible faces in order and registers one result per face with its occlusion
module vfcao_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  vfcao_pkg::cube_t            cube,
  input  logic [vfcao_pkg::MAT_W-1:0] material,
  input  logic                        out_ready,
  output logic                        out_valid,
  output vfcao_pkg::face_res_t        res,
  output logic                        busy
);
  import vfcao_pkg::*;

  logic [NUM_FACES-1:0] vis;
  logic [NUM_FACES-1:0] rem;
  logic [NUM_FACES-1:0] nxt_bit;
  face_t                nxt;
  logic                 load;

  // a face shows when its neighbor is air
  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      vis[f] = ~cube[FACE_NBR[f]];
    end
  end

  // lowest remaining face goes first
  always_comb begin
    nxt     = '0;
    nxt_bit = '0;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (rem[i]) begin
        nxt     = FACE_W'(i);
        nxt_bit = NUM_FACES'(1) << i;
      end
    end
  end

  assign load = (rem != '0) && (!out_valid || out_ready);
  assign busy = (rem != '0) || out_valid;

  // face mask and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        rem <= (material != '0) ? vis : '0;
      end else if (load) begin
        rem <= rem & ~nxt_bit;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      res.face_id  <= nxt;
      res.occl_v0  <= ao_level(cube, nxt, 2'd0);
      res.occl_v1  <= ao_level(cube, nxt, 2'd1);
      res.occl_v2  <= ao_level(cube, nxt, 2'd2);
      res.occl_v3  <= ao_level(cube, nxt, 2'd3);
      res.material <= material;
      res.last     <= ((rem & ~nxt_bit) == '0);
    end
  end

endmodule

// ----- rtl/voxel_face_cull_ambient_occlusion_core.sv -----
// Voxel face culling with per-vertex ambient occlusion for one chunk.
// After reset the material store is swept to air one entry per cycle; no
// request is taken during that sweep. A write request goes straight into the
// store. A mesh request reads its 27-voxel neighborhood through the single
// store read port, one voxel per cycle; the input stays held off through the
// read latency, the face pick and the output of every visible face, also while
// the output is stalled. One request is worked on at a time. Cells outside the
// chunk read as solid or air per the border_solid register (reset: solid).
module voxel_face_cull_ambient_occlusion_core #(
  parameter int CHUNK_X = 32,
  parameter int CHUNK_Y = 256,
  parameter int CHUNK_Z = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               req_type,
  input  logic [vfcao_pkg::POSX_W-1:0]       pos_x,
  input  logic [vfcao_pkg::POSY_W-1:0]       pos_y,
  input  logic [vfcao_pkg::POSZ_W-1:0]       pos_z,
  input  logic [vfcao_pkg::MAT_W-1:0]        material,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [vfcao_pkg::FACE_W-1:0]       face_id,
  output logic [vfcao_pkg::OCCL_W-1:0]       occl_v0,
  output logic [vfcao_pkg::OCCL_W-1:0]       occl_v1,
  output logic [vfcao_pkg::OCCL_W-1:0]       occl_v2,
  output logic [vfcao_pkg::OCCL_W-1:0]       occl_v3,
  output logic [vfcao_pkg::MAT_W-1:0]        face_material,
  output logic                               last_face
);
  import vfcao_pkg::*;

  localparam int DEPTH   = CHUNK_X * CHUNK_Y * CHUNK_Z;
  localparam int AW      = $clog2(DEPTH);
  localparam int DIM_XZ  = (CHUNK_X > CHUNK_Z) ? CHUNK_X : CHUNK_Z;
  localparam int DIM_MAX = (DIM_XZ > CHUNK_Y) ? DIM_XZ : CHUNK_Y;
  localparam int DIM_W   = $clog2(DIM_MAX + 1);
  localparam int CW      = ((DIM_W > POSY_W) ? DIM_W : POSY_W) + 2;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_GATHER = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  state_t               state;
  state_t               state_next;
  logic                 border_solid;
  logic                 accept;
  logic                 pos_inside;
  logic                 clearing;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [CW-1:0] cz;
  logic                 g_start;
  logic                 g_done;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [MAT_W-1:0]     rd_data;
  cube_t                cube;
  logic [MAT_W-1:0]     center_mat;
  logic                 emit_busy;
  face_res_t            res;

  // border register
  always_ff @(posedge clk) begin
    if (rst) begin
      border_solid <= 1'b1;
    end else if (cfg_wr_en) begin
      border_solid <= cfg_wr_data;
    end
  end

  // request handshake
  assign in_ready   = (state == ST_IDLE) && !clearing;
  assign accept     = in_valid && in_ready;
  assign pos_inside = (int'(pos_x) < CHUNK_X) && (int'(pos_y) < CHUNK_Y) &&
                      (int'(pos_z) < CHUNK_Z);

  // voxel write straight into the store
  assign wr_en   = accept && (req_type == REQ_WRITE) && pos_inside;
  assign wr_addr = AW'(pos_x) + AW'(pos_y) * AW'(CHUNK_X) +
                   AW'(pos_z) * AW'(CHUNK_X * CHUNK_Y);

  assign g_start = accept && (req_type == REQ_MESH) && pos_inside;

  // hold the meshed position for the neighborhood walk
  always_ff @(posedge clk) begin
    if (g_start) begin
      cx <= $signed(CW'(pos_x));
      cy <= $signed(CW'(pos_y));
      cz <= $signed(CW'(pos_z));
    end
  end

  // request sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (g_start) begin
          state_next = ST_GATHER;
        end
      end
      ST_GATHER: begin
        if (g_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  vfcao_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (material),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  vfcao_gather #(
    .CHUNK_X (CHUNK_X),
    .CHUNK_Y (CHUNK_Y),
    .CHUNK_Z (CHUNK_Z),
    .CW      (CW),
    .AW      (AW)
  ) u_gather (
    .clk          (clk),
    .rst          (rst),
    .start        (g_start),
    .cx           (cx),
    .cy           (cy),
    .cz           (cz),
    .border_solid (border_solid),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .cube         (cube),
    .material     (center_mat),
    .done         (g_done)
  );

  // face masks are taken on the last read, which is the corner and no face neighbor
  vfcao_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (g_done),
    .cube      (cube),
    .material  (center_mat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res       (res),
    .busy      (emit_busy)
  );

  assign face_id       = res.face_id;
  assign occl_v0       = res.occl_v0;
  assign occl_v1       = res.occl_v1;
  assign occl_v2       = res.occl_v2;
  assign occl_v3       = res.occl_v3;
  assign face_material = res.material;
  assign last_face     = res.last;

`ifndef SYNTHESIS
  a_no_out_when_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("result pending while a new request is taken");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_face) |=> !out_valid)
    else $error("result after the last face of a request");

  a_done_in_gather: assert property (@(posedge clk) disable iff (rst)
    g_done |-> (state == ST_GATHER))
    else $error("neighborhood walk finished outside gather");
`endif

endmodule

// ----- verif/tb_voxel_face_cull_ambient_occlusion_core.sv -----
// testbench for the voxel face cull and vertex occlusion core: directed and random requests
`timescale 1ns / 100ps

module tb_voxel_face_cull_ambient_occlusion_core;
  import vfcao_pkg::*;

  localparam int CHUNK_X      = 32;
  localparam int CHUNK_Y      = 256;
  localparam int CHUNK_Z      = 32;
  localparam int STORE_N      = CHUNK_X * CHUNK_Y * CHUNK_Z;
  localparam int SETTLE_CYC   = 64;
  localparam int HOLD_CYCLES  = 500;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int CLUSTERS     = 5;

  // face normals: back, front, left, right, bottom, top
  localparam int FACE_OFS [6][3] = '{
    '{0, 0, 1}, '{0, 0, -1}, '{1, 0, 0}, '{-1, 0, 0}, '{0, -1, 0}, '{0, 1, 0}
  };

  // per face, per vertex: side 1, side 2, corner as dx, dy, dz
  localparam int AO_OFS [6][4][3][3] = '{
    '{'{'{1, 0, 1}, '{0, 1, 1}, '{1, 1, 1}},
      '{'{0, 1, 1}, '{-1, 0, 1}, '{-1, 1, 1}},
      '{'{-1, 0, 1}, '{0, -1, 1}, '{-1, -1, 1}},
      '{'{0, -1, 1}, '{1, 0, 1}, '{1, -1, 1}}},
    '{'{'{-1, 0, -1}, '{0, 1, -1}, '{-1, 1, -1}},
      '{'{0, 1, -1}, '{1, 0, -1}, '{1, 1, -1}},
      '{'{1, 0, -1}, '{0, -1, -1}, '{1, -1, -1}},
      '{'{0, -1, -1}, '{-1, 0, -1}, '{-1, -1, -1}}},
    '{'{'{1, 0, -1}, '{1, 1, 0}, '{1, 1, -1}},
      '{'{1, 1, 0}, '{1, 0, 1}, '{1, 1, 1}},
      '{'{1, 0, 1}, '{1, -1, 0}, '{1, -1, 1}},
      '{'{1, -1, 0}, '{1, 0, -1}, '{1, -1, -1}}},
    '{'{'{-1, 0, 1}, '{-1, 1, 0}, '{-1, 1, 1}},
      '{'{-1, 1, 0}, '{-1, 0, -1}, '{-1, 1, -1}},
      '{'{-1, 0, -1}, '{-1, -1, 0}, '{-1, -1, -1}},
      '{'{-1, -1, 0}, '{-1, 0, 1}, '{-1, -1, 1}}},
    '{'{'{-1, -1, 0}, '{0, -1, -1}, '{-1, -1, -1}},
      '{'{0, -1, -1}, '{1, -1, 0}, '{1, -1, -1}},
      '{'{1, -1, 0}, '{0, -1, 1}, '{1, -1, 1}},
      '{'{0, -1, 1}, '{-1, -1, 0}, '{-1, -1, 1}}},
    '{'{'{-1, 1, 0}, '{0, 1, 1}, '{-1, 1, 1}},
      '{'{0, 1, 1}, '{1, 1, 0}, '{1, 1, 1}},
      '{'{1, 1, 0}, '{0, 1, -1}, '{1, 1, -1}},
      '{'{0, 1, -1}, '{-1, 1, 0}, '{-1, 1, -1}}}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic in_valid;
  logic in_ready;
  logic req_type;
  logic [POSX_W-1:0] pos_x;
  logic [POSY_W-1:0] pos_y;
  logic [POSZ_W-1:0] pos_z;
  logic [MAT_W-1:0] material;
  logic out_valid;
  logic out_ready;
  logic [FACE_W-1:0] face_id;
  logic [OCCL_W-1:0] occl_v0;
  logic [OCCL_W-1:0] occl_v1;
  logic [OCCL_W-1:0] occl_v2;
  logic [OCCL_W-1:0] occl_v3;
  logic [MAT_W-1:0] face_material;
  logic last_face;

  // shadow of the chunk and the border register
  bit [MAT_W-1:0] vox_mem [STORE_N];
  bit border_solid_m = 1'b1;
  face_res_t pending_faces [$];
  face_res_t want;

  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  int burst_left = 0;

  // receiver stall pattern and long hold-off
  logic [7:0] ready_pat = 8'hFF;
  logic [5:0] ready_tick = '0;
  logic hold_on = 1'b0;
  event hold_go;

  voxel_face_cull_ambient_occlusion_core #(
    .CHUNK_X(CHUNK_X),
    .CHUNK_Y(CHUNK_Y),
    .CHUNK_Z(CHUNK_Z)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .material(material),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .face_id(face_id),
    .occl_v0(occl_v0),
    .occl_v1(occl_v1),
    .occl_v2(occl_v2),
    .occl_v3(occl_v3),
    .face_material(face_material),
    .last_face(last_face)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[voxel_face_cull_ambient_occlusion_core] ERROR");
      $finish;
    end
  end

  // output ready: rotating stall pattern, reloaded at random whenever the tick counter wraps
  always @(posedge clk) begin
    ready_tick <= ready_tick + 6'd1;
    if (ready_tick == 6'd63) begin
      ready_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end else begin
      ready_pat <= {ready_pat[0], ready_pat[7:1]};
    end
    out_ready <= !hold_on && ready_pat[0];
  end

  // long output hold-off, counted here
  always begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < 40) begin
      $display("t=%0t mismatch: %s", $time, msg);
    end
    mismatch_cnt++;
  endtask

  function automatic bit solid_cell(int x, int y, int z);
    if (x < 0 || x >= CHUNK_X || y < 0 || y >= CHUNK_Y || z < 0 || z >= CHUNK_Z) begin
      return border_solid_m;
    end
    return vox_mem[x + y * CHUNK_X + z * CHUNK_X * CHUNK_Y] != '0;
  endfunction

  // expected visible faces of one meshed voxel, appended in face order
  function automatic void predict_faces(int x, int y, int z);
    logic [MAT_W-1:0] mat;
    face_res_t res;
    face_res_t faces [$];
    logic [OCCL_W-1:0] lvl [4];
    bit s0;
    bit s1;
    bit s2;
    mat = vox_mem[x + y * CHUNK_X + z * CHUNK_X * CHUNK_Y];
    if (mat == '0) return;
    for (int f = 0; f < NUM_FACES; f++) begin
      if (!solid_cell(x + FACE_OFS[f][0], y + FACE_OFS[f][1], z + FACE_OFS[f][2])) begin
        for (int v = 0; v < 4; v++) begin
          s0 = solid_cell(x + AO_OFS[f][v][0][0], y + AO_OFS[f][v][0][1],
                          z + AO_OFS[f][v][0][2]);
          s1 = solid_cell(x + AO_OFS[f][v][1][0], y + AO_OFS[f][v][1][1],
                          z + AO_OFS[f][v][1][2]);
          s2 = solid_cell(x + AO_OFS[f][v][2][0], y + AO_OFS[f][v][2][1],
                          z + AO_OFS[f][v][2][2]);
          lvl[v] = (s0 && s1) ? 2'd0 : 2'(3 - (int'(s0) + int'(s1) + int'(s2)));
        end
        res.face_id  = face_t'(f);
        res.occl_v0  = lvl[0];
        res.occl_v1  = lvl[1];
        res.occl_v2  = lvl[2];
        res.occl_v3  = lvl[3];
        res.material = mat;
        res.last     = 1'b0;
        faces = {faces, res};
      end
    end
    if (faces.size() > 0) faces[faces.size() - 1].last = 1'b1;
    foreach (faces[i]) pending_faces = {pending_faces, faces[i]};
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_faces.size() == 0) begin
        report_mismatch($sformatf("face %0d with no request pending", face_id));
      end else begin
        want = pending_faces.pop_front();
        if (face_id !== want.face_id)
          report_mismatch($sformatf("face_id %0d, want %0d", face_id, want.face_id));
        if (occl_v0 !== want.occl_v0)
          report_mismatch($sformatf("occl_v0 %0d, want %0d", occl_v0, want.occl_v0));
        if (occl_v1 !== want.occl_v1)
          report_mismatch($sformatf("occl_v1 %0d, want %0d", occl_v1, want.occl_v1));
        if (occl_v2 !== want.occl_v2)
          report_mismatch($sformatf("occl_v2 %0d, want %0d", occl_v2, want.occl_v2));
        if (occl_v3 !== want.occl_v3)
          report_mismatch($sformatf("occl_v3 %0d, want %0d", occl_v3, want.occl_v3));
        if (face_material !== want.material)
          report_mismatch($sformatf("face_material %0d, want %0d", face_material,
                                    want.material));
        if (last_face !== want.last)
          report_mismatch($sformatf("last_face %0d, want %0d", last_face, want.last));
      end
    end
  end

  // offer one request in bursts with random gaps, update the shadow on accept
  task automatic send_req(req_type_t kind, int x, int y, int z, int mat);
    logic [POSX_W-1:0] px;
    logic [POSY_W-1:0] py;
    logic [POSZ_W-1:0] pz;
    logic [MAT_W-1:0]  pm;
    px = POSX_W'(x);
    py = POSY_W'(y);
    pz = POSZ_W'(z);
    pm = MAT_W'(mat);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= kind;
    pos_x    <= px;
    pos_y    <= py;
    pos_z    <= pz;
    material <= pm;
    do @(posedge clk); while (!in_ready);
    if (kind == REQ_WRITE) begin
      vox_mem[int'(px) + int'(py) * CHUNK_X + int'(pz) * CHUNK_X * CHUNK_Y] = pm;
    end else begin
      predict_faces(int'(px), int'(py), int'(pz));
    end
  endtask

  // drop valid, wait for all faces, then let a zero-face mesh finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_faces.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_border(bit solid);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= solid;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    border_solid_m = solid;
  endtask

  // base of a 3-wide box, often at a chunk edge
  function automatic int pick_base(int hi);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  // fill a small box at random, then send mostly meshes of the written voxels
  task automatic fill_and_mesh_cluster();
    int bx;
    int by;
    int bz;
    int x;
    int y;
    int z;
    int pick;
    int wx [$];
    int wy [$];
    int wz [$];
    bx = pick_base(CHUNK_X - 3);
    by = pick_base(CHUNK_Y - 3);
    bz = pick_base(CHUNK_Z - 3);
    repeat (14) begin
      x = bx + $urandom_range(0, 2);
      y = by + $urandom_range(0, 2);
      z = bz + $urandom_range(0, 2);
      send_req(REQ_WRITE, x, y, z,
               ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(1, 127)));
      wx = {wx, x};
      wy = {wy, y};
      wz = {wz, z};
    end
    repeat (10) begin
      case ($urandom_range(0, 9))
        0: send_req(REQ_MESH, $urandom, $urandom, $urandom, $urandom);
        1: send_req(REQ_WRITE, bx + $urandom_range(0, 2), by + $urandom_range(0, 2),
                    bz + $urandom_range(0, 2), $urandom);
        2: send_req(REQ_WRITE, $urandom, $urandom, $urandom, $urandom);
        default: begin
          pick = $urandom_range(0, wx.size() - 1);
          send_req(REQ_MESH, wx[pick], wy[pick], wz[pick], $urandom);
        end
      endcase
    end
  endtask

  // lone voxels at the chunk corners with a solid border, and an air voxel
  task automatic test_corner_voxels();
    send_req(REQ_WRITE, 0, 0, 0, 127);
    send_req(REQ_MESH, 0, 0, 0, 0);
    send_req(REQ_WRITE, 31, 255, 31, 1);
    send_req(REQ_MESH, 31, 255, 31, 127);
    send_req(REQ_MESH, 5, 5, 5, 0);
    send_req(REQ_WRITE, 1, 0, 0, 64);
    send_req(REQ_MESH, 0, 0, 0, 0);
  endtask

  // fully enclosed voxel shows nothing, then opening the top
  task automatic test_enclosed_voxel();
    send_req(REQ_WRITE, 16, 128, 16, 'h2A);
    for (int f = 0; f < NUM_FACES; f++) begin
      send_req(REQ_WRITE, 16 + FACE_OFS[f][0], 128 + FACE_OFS[f][1],
               16 + FACE_OFS[f][2], 'h55);
    end
    send_req(REQ_MESH, 16, 128, 16, 0);
    send_req(REQ_WRITE, 16, 129, 16, 0);
    send_req(REQ_MESH, 16, 128, 16, 0);
    send_req(REQ_MESH, 17, 128, 16, 0);
  endtask

  // border read as air: corner voxels show faces toward the outside
  task automatic test_border_air();
    send_req(REQ_MESH, 0, 0, 0, 0);
    send_req(REQ_MESH, 31, 255, 31, 0);
    send_req(REQ_WRITE, 0, 1, 0, 3);
    send_req(REQ_MESH, 0, 0, 0, 0);
  endtask

  task automatic test_random_clusters(int n);
    repeat (n) fill_and_mesh_cluster();
  endtask

  // output held off while requests keep coming, so the input stalls
  task automatic test_output_hold();
    -> hold_go;
    fill_and_mesh_cluster();
  endtask

  initial begin
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid    = 1'b0;
    req_type    = 1'b0;
    pos_x       = '0;
    pos_y       = '0;
    pos_z       = '0;
    material    = '0;
    out_ready   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_corner_voxels();
    test_enclosed_voxel();
    set_border(1'b0);
    test_border_air();
    test_random_clusters(CLUSTERS);
    set_border(1'b1);
    test_random_clusters(CLUSTERS);
    test_output_hold();
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("[voxel_face_cull_ambient_occlusion_core] OK");
    end else begin
      $display("[voxel_face_cull_ambient_occlusion_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/vfcao_pkg.sv
rtl/vfcao_store.sv
rtl/vfcao_gather.sv
rtl/vfcao_emit.sv
rtl/voxel_face_cull_ambient_occlusion_core.sv
verif/tb_voxel_face_cull_ambient_occlusion_core.sv
